// File: rtl/ffca_pkg.sv
// shared types and constants of the first-fit chunk allocator
package ffca_pkg;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_POOL_SIZE  = 2'd1;
    localparam logic [1:0] REG_CHECK_ZERO = 2'd2;

    localparam int unsigned BYTES_MAX = 32'h7FFF;

    typedef struct packed {
        logic        cmd;
        logic [14:0] req_size;
        logic [15:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] grant_addr;
        logic [1:0]  status;
    } t_rsp;

endpackage

// File: rtl/ffca_if.sv
// valid/ready channel carrying one payload
interface ffca_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/first_fit_chunk_allocator.sv
// first-fit chunk allocator: top level with chunk table and sequencer
// Each request is handled by a small sequencer walking the chunk table one
// entry per cycle; the table itself is held in registers. An allocate walks
// from the first entry to the first free one that fits, or past the last
// entry when nothing fits; for a split it then moves the entries above up one
// place, checks and writes the split, and hands the result to the output
// register. A free walks to the matching entry and then runs a coalesce pass
// over every table entry. One request is in service at a time; the result
// moves to an output register, so the next request is taken while it waits,
// and a following result waits in the sequencer until that register is free.
// A write to pool_base or pool_size restarts the pool as one free chunk at
// once.
module first_fit_chunk_allocator
    import ffca_pkg::*;
#(
    parameter int MAX_CHUNKS   = 32,
    parameter int HEADER_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    ffca_if.sink        i_req,
    ffca_if.source      o_rsp
);

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHUNKS);
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);
    localparam logic [15:0] PSIZE_RST = 16'd4096;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // chunk table held in registers
    logic [15:0] r_off  [MAX_CHUNKS];
    logic [14:0] r_size [MAX_CHUNKS];
    logic        r_free [MAX_CHUNKS];
    logic [CW-1:0] r_cnt;

    logic [15:0] r_base;
    logic [15:0] r_psize;
    logic        r_chkz;
    logic [2:0]  r_state;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_k;
    t_req        r_req;
    t_rsp        r_res;
    t_rsp        r_rsp;
    logic        r_ovld;
    logic [CW-1:0] r_rd;

    logic [IW-1:0] idx;
    logic [15:0]   cur_addr;
    logic [16:0]   need;
    logic [15:0]   psz_src;
    logic [14:0]   init_size;
    logic [16:0]   psz_m;
    logic [16:0]   msum;
    logic          pool_reinit;
    logic          handoff;

    assign idx      = r_i[IW-1:0];
    assign need     = {2'b0, r_req.req_size} + HDR;
    assign cur_addr = r_base + r_off[idx] + HDR[15:0];
    // pool size seen by a restart: reset value or the value being written
    assign psz_src  = !i_rst_n ? PSIZE_RST :
        ((i_cfg_we && i_cfg_index == REG_POOL_SIZE) ? i_cfg_data : r_psize);
    assign psz_m    = ({1'b0, psz_src} > HDR) ? ({1'b0, psz_src} - HDR) : 17'd0;
    assign init_size = (psz_m > 17'(BYTES_MAX)) ? 15'h7FFF : psz_m[14:0];
    assign pool_reinit = !i_rst_n || (i_cfg_we &&
        (i_cfg_index == REG_POOL_BASE || i_cfg_index == REG_POOL_SIZE));
    assign handoff = (r_state == S_OUT) && (!r_ovld || o_rsp.ready);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 16'd0;
            r_psize <= PSIZE_RST;
            r_chkz  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POOL_BASE:  r_base  <= i_cfg_data;
                REG_POOL_SIZE:  r_psize <= i_cfg_data;
                REG_CHECK_ZERO: r_chkz  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register, loaded from the sequencer result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_rsp  <= '0;
        end else if (handoff) begin
            r_ovld <= 1'b1;
            r_rsp  <= r_res;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    // merge accumulator: current kept entry plus next one plus header
    logic [IW-1:0] wi, ri;
    assign wi   = r_k[IW-1:0];
    assign ri   = r_rd[IW-1:0];
    assign msum = {2'b0, r_size[wi]} + {2'b0, r_size[ri]} + HDR;

    // sequencer and table updates
    always_ff @(posedge i_clk) begin
        if (pool_reinit) begin
            r_state <= S_IDLE;
            r_cnt   <= CW'(1);
            r_off[0] <= 16'd0;
            r_size[0] <= init_size;
            r_free[0] <= 1'b1;
            if (!i_rst_n) r_res <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_i   <= '0;
                        if (i_req.data.cmd == CMD_ALLOC && i_req.data.req_size == 15'd0
                                && r_chkz) begin
                            r_res   <= '{grant_addr: 16'd0, status: ST_BAD};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                // one table entry examined per cycle
                S_WALK: begin
                    if (r_i >= r_cnt) begin
                        r_res <= '{grant_addr: 16'd0,
                            status: (r_req.cmd == CMD_FREE) ? ST_BAD : ST_NOFIT};
                        r_state <= S_OUT;
                    end else if (r_req.cmd == CMD_FREE) begin
                        if (!r_free[idx] && cur_addr == r_req.free_addr) begin
                            r_free[idx] <= 1'b1;
                            r_res <= '{grant_addr: 16'd0, status: ST_DONE};
                            r_k   <= '0;
                            r_rd  <= CW'(1);
                            r_state <= S_MERGE;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else if (r_free[idx]) begin
                        if (r_size[idx] == r_req.req_size) begin
                            r_free[idx] <= 1'b0;
                            r_res <= '{grant_addr: cur_addr, status: ST_DONE};
                            r_state <= S_OUT;
                        end else if ({2'b0, r_size[idx]} > need) begin
                            if (r_cnt >= CNT_MAX) begin
                                r_res <= '{grant_addr: 16'd0, status: ST_FULL};
                                r_state <= S_OUT;
                            end else begin
                                r_k <= r_cnt;
                                r_state <= S_SHIFT;
                            end
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                // move entries up one place, top first
                S_SHIFT: begin
                    if (r_k > r_i + CW'(1)) begin
                        r_off[r_k[IW-1:0]]  <= r_off[r_k[IW-1:0] - IW'(1)];
                        r_size[r_k[IW-1:0]] <= r_size[r_k[IW-1:0] - IW'(1)];
                        r_free[r_k[IW-1:0]] <= r_free[r_k[IW-1:0] - IW'(1)];
                        r_k <= r_k - CW'(1);
                    end else begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_off[idx + IW'(1)]  <= r_off[idx] + need[15:0];
                    r_size[idx + IW'(1)] <= 15'({2'b0, r_size[idx]} - need);
                    r_free[idx + IW'(1)] <= 1'b1;
                    r_size[idx] <= r_req.req_size;
                    r_free[idx] <= 1'b0;
                    r_cnt <= r_cnt + CW'(1);
                    r_res <= '{grant_addr: cur_addr, status: ST_DONE};
                    r_state <= S_OUT;
                end
                // single compaction pass: k is kept entry, rd is next entry
                S_MERGE: begin
                    if (r_rd >= r_cnt) begin
                        r_cnt <= r_k + CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        if (r_free[wi] && r_free[ri]) begin
                            r_size[wi] <= (msum > 17'(BYTES_MAX)) ? 15'h7FFF : msum[14:0];
                        end else begin
                            r_off[wi + IW'(1)]  <= r_off[ri];
                            r_size[wi + IW'(1)] <= r_size[ri];
                            r_free[wi + IW'(1)] <= r_free[ri];
                            r_k <= r_k + CW'(1);
                        end
                        r_rd <= r_rd + CW'(1);
                    end
                end
                // wait for the output register to take the result
                S_OUT: begin
                    if (handoff) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: dv/first_fit_chunk_allocator_tb.sv
// self-checking testbench of the first-fit chunk allocator
`timescale 1ns / 100ps

module first_fit_chunk_allocator_tb;
    import ffca_pkg::*;

    localparam int MAX_CHUNKS   = 32;
    localparam int HEADER_BYTES = 4;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        t_rsp rsp;
        bit   is_alloc;
    } t_awaited;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    ffca_if #(.T(t_req)) req_if ();
    ffca_if #(.T(t_rsp)) rsp_if ();

    first_fit_chunk_allocator #(
        .MAX_CHUNKS(MAX_CHUNKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_req(req_if.sink),
        .o_rsp(rsp_if.source)
    );

    // shadow of the chunk table and pool registers
    int unsigned heap_off [MAX_CHUNKS];
    int unsigned heap_len [MAX_CHUNKS];
    bit          heap_free [MAX_CHUNKS];
    int unsigned heap_cnt;
    int unsigned pool_base_q;
    int unsigned pool_size_q;
    bit          zero_check_q;

    t_req        req_pending [$];
    t_awaited    rsp_awaited [$];
    logic [15:0] live_ptrs [$];
    logic [15:0] freed_ptrs [$];
    int          errors = 0;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_timer;
    int          idle_cycles;

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] chunk_ptr(int unsigned i);
        return 16'(pool_base_q + heap_off[i] + HEADER_BYTES);
    endfunction

    // pool restart after reset or a base/size write
    function automatic void pool_restart();
        int unsigned b;
        b = 0;
        if (pool_size_q > HEADER_BYTES) b = pool_size_q - HEADER_BYTES;
        if (b > BYTES_MAX) b = BYTES_MAX;
        for (int k = 0; k < MAX_CHUNKS; k++) begin
            heap_off[k] = 0;
            heap_len[k] = 0;
            heap_free[k] = 1'b0;
        end
        heap_len[0] = b;
        heap_free[0] = 1'b1;
        heap_cnt = 1;
    endfunction

    // first-fit allocate or free with full coalesce, updates the shadow table
    function automatic t_rsp apply_request(t_req r);
        t_rsp        o;
        int unsigned need;
        int unsigned s;
        o.grant_addr = '0;
        if (r.cmd == CMD_ALLOC) begin
            o.status = ST_NOFIT;
            need = r.req_size + HEADER_BYTES;
            if (r.req_size == 0 && zero_check_q) begin
                o.status = ST_BAD;
            end else begin
                for (int unsigned i = 0; i < heap_cnt; i++) begin
                    if (!heap_free[i]) continue;
                    if (heap_len[i] == r.req_size) begin
                        heap_free[i] = 1'b0;
                        o.grant_addr = chunk_ptr(i);
                        o.status = ST_DONE;
                        break;
                    end
                    if (heap_len[i] > need) begin
                        if (heap_cnt >= MAX_CHUNKS) begin
                            o.status = ST_FULL;
                            break;
                        end
                        for (int unsigned k = heap_cnt; k > i + 1; k--) begin
                            heap_off[k] = heap_off[k-1];
                            heap_len[k] = heap_len[k-1];
                            heap_free[k] = heap_free[k-1];
                        end
                        heap_off[i+1] = (heap_off[i] + need) & 16'hFFFF;
                        heap_len[i+1] = heap_len[i] - need;
                        heap_free[i+1] = 1'b1;
                        heap_len[i] = r.req_size;
                        heap_free[i] = 1'b0;
                        heap_cnt++;
                        o.grant_addr = chunk_ptr(i);
                        o.status = ST_DONE;
                        break;
                    end
                end
            end
        end else begin
            o.status = ST_BAD;
            for (int unsigned i = 0; i < heap_cnt; i++) begin
                if (!heap_free[i] && chunk_ptr(i) == r.free_addr) begin
                    heap_free[i] = 1'b1;
                    o.status = ST_DONE;
                    break;
                end
            end
            // merge every run of neighboring free chunks
            if (o.status == ST_DONE) begin
                int unsigned j;
                j = 0;
                while (j + 1 < heap_cnt) begin
                    if (heap_free[j] && heap_free[j+1]) begin
                        s = heap_len[j] + heap_len[j+1] + HEADER_BYTES;
                        heap_len[j] = (s > BYTES_MAX) ? BYTES_MAX : s;
                        for (int unsigned k = j + 1; k + 1 < heap_cnt; k++) begin
                            heap_off[k] = heap_off[k+1];
                            heap_len[k] = heap_len[k+1];
                            heap_free[k] = heap_free[k+1];
                        end
                        heap_cnt--;
                    end else begin
                        j++;
                    end
                end
            end
        end
        return o;
    endfunction

    // request driver: bursts with random gaps, prediction on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end else begin
            if (req_if.valid && req_if.ready)
                rsp_awaited.push_back('{apply_request(req_if.data),
                                        req_if.data.cmd == CMD_ALLOC});
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_if.valid <= 1'b0;
                end else if (req_pending.size() > 0) begin
                    req_if.valid <= 1'b1;
                    req_if.data <= req_pending.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_mode <= 0;
            stall_timer <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_awaited.size() == 0) begin
                    $display("%0t: unexpected transfer, actual addr %h status %0d",
                             $time, rsp_if.data.grant_addr, rsp_if.data.status);
                    errors++;
                end else begin
                    t_awaited a;
                    a = rsp_awaited.pop_front();
                    if (rsp_if.data.grant_addr !== a.rsp.grant_addr) begin
                        $display("%0t: grant_addr expected %h actual %h",
                                 $time, a.rsp.grant_addr, rsp_if.data.grant_addr);
                        errors++;
                    end
                    if (rsp_if.data.status !== a.rsp.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, a.rsp.status, rsp_if.data.status);
                        errors++;
                    end
                    if (a.is_alloc && a.rsp.status == ST_DONE)
                        live_ptrs.push_back(a.rsp.grant_addr);
                end
            end
            if (stall_timer == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(20, 80);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0: begin
                    rsp_if.ready <= 1'b1;
                end
                1: begin
                    rsp_if.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("first_fit_chunk_allocator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_POOL_BASE: begin
                pool_base_q = 32'(val);
                pool_restart();
            end
            REG_POOL_SIZE: begin
                pool_size_q = 32'(val);
                pool_restart();
            end
            REG_CHECK_ZERO: begin
                zero_check_q = val[0];
            end
            default: begin
            end
        endcase
        live_ptrs.delete();
        freed_ptrs.delete();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_pending.size() > 0 || rsp_awaited.size() > 0 || req_if.valid);
    endtask

    function automatic t_req make_alloc(int unsigned sz);
        t_req r;
        r.cmd = CMD_ALLOC;
        r.req_size = sz[14:0];
        r.free_addr = 16'($urandom);
        return r;
    endfunction

    function automatic t_req make_free(logic [15:0] ptr);
        t_req r;
        r.cmd = CMD_FREE;
        r.req_size = 15'($urandom);
        r.free_addr = ptr;
        return r;
    endfunction

    // one batch of random traffic, frees mostly drawn from granted pointers
    task automatic random_batch(int n, int alloc_pct);
        int          pick;
        int          idx;
        logic [15:0] p;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    req_pending.push_back(make_alloc($urandom_range(0, 48)));
                else if (pick < 92)
                    req_pending.push_back(make_alloc($urandom_range(0, pool_size_q + 8)
                                                     & 16'h7FFF));
                else
                    req_pending.push_back(make_alloc($urandom_range(0, 32767)));
            end else if (live_ptrs.size() > 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, live_ptrs.size() - 1);
                p = live_ptrs[idx];
                live_ptrs.delete(idx);
                freed_ptrs.push_back(p);
                req_pending.push_back(make_free(p));
            end else if (freed_ptrs.size() > 0 && $urandom_range(0, 1) == 0) begin
                req_pending.push_back(make_free(freed_ptrs[$urandom_range(0,
                                                 freed_ptrs.size() - 1)]));
            end else begin
                req_pending.push_back(make_free(16'($urandom)));
            end
        end
        wait_drained();
    endtask

    task automatic random_phase(int batches);
        for (int b = 0; b < batches; b++)
            random_batch($urandom_range(4, 12), ($urandom_range(0, 2) == 0) ? 85 : 55);
    endtask

    // reset, directed cases, then random phases over several pool settings
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pool_base_q = 0;
        pool_size_q = 4096;
        zero_check_q = 1'b1;
        pool_restart();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // rejected zero size, no fit, split, double free, exact reuse
        req_pending.push_back(make_alloc(0));
        req_pending.push_back(make_alloc(32767));
        req_pending.push_back(make_alloc(16));
        req_pending.push_back(make_alloc(24));
        req_pending.push_back(make_free(16'd4));
        req_pending.push_back(make_free(16'd4));
        req_pending.push_back(make_alloc(16));
        req_pending.push_back(make_free(16'hFFFF));
        req_pending.push_back(make_free(16'h0000));
        req_pending.push_back(make_free(16'd24));
        req_pending.push_back(make_free(16'd4));
        req_pending.push_back(make_alloc(4092));
        req_pending.push_back(make_free(16'd4));
        wait_drained();

        // zero size allowed, wrapped base
        write_reg(REG_CHECK_ZERO, 16'd0);
        write_reg(REG_POOL_BASE, 16'hFFF0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        req_pending.push_back(make_alloc(0));
        req_pending.push_back(make_alloc(0));
        req_pending.push_back(make_alloc(8));
        wait_drained();
        random_phase(15);

        // table fill
        for (int k = 0; k < 34; k++)
            req_pending.push_back(make_alloc($urandom_range(0, 8)));
        wait_drained();
        random_phase(10);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_SIZE, 16'd8);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(6);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_SIZE, 16'd2);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(4);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_BASE, 16'h1234);
        write_reg(REG_POOL_SIZE, 16'd32768);
        write_reg(REG_CHECK_ZERO, 16'd1);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(20);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_SIZE, 16'hFFFF);
        write_reg(REG_POOL_BASE, 16'hFFFF);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(15);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_BASE, 16'h0000);
        write_reg(REG_POOL_SIZE, 16'd512);
        write_reg(REG_CHECK_ZERO, 16'd0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(20);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_POOL_SIZE, 16'd4096);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        random_phase(20);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && rsp_awaited.size() == 0) begin
            $display("first_fit_chunk_allocator regression: pass");
        end else begin
            $display("first_fit_chunk_allocator regression: fail");
        end
        $finish;
    end

endmodule
